>>> sv/tpc_pkg.sv
// shared constants, types and codes of the triangle plane clipper
`default_nettype none
package tpc_pkg;
	localparam int CW = 32;                     // coordinate width
	localparam int FB = 16;                     // fraction bits
	localparam int WB = 60;                     // weight width after normalizing
	localparam int WH = WB / 2;                 // weight half for split multiply
	localparam int PW = 2 * CW;                 // normal times coordinate
	localparam int DW = 2 * CW + 3;             // plane distance
	localparam int SHW = $clog2(DW - WB + 1);   // weight shift amount
	localparam int FW = CW + 1;                 // coordinate difference
	localparam int QW = CW + 1;                 // biased quotient
	localparam int MPW = FW + WH + 1;           // partial product
	localparam int DVW = WB + 2;                // divisor, twice the weight sum
	localparam int MW = CW + WB + 3;            // biased dividend
	localparam int NREG = 4;
	localparam int RIW = $clog2(NREG);
	localparam int APB_DW = (CW > 32) ? 64 : 32;
	localparam int ASH = (CW > 32) ? 3 : 2;
	localparam int AW = RIW + ASH;

	localparam logic [RIW-1:0] REG_NX = RIW'(0);
	localparam logic [RIW-1:0] REG_NY = RIW'(1);
	localparam logic [RIW-1:0] REG_NZ = RIW'(2);
	localparam logic [RIW-1:0] REG_OFF = RIW'(3);

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_ONE = 2'd1;
	localparam logic [1:0] MODE_TWO = 2'd2;
	localparam logic [1:0] MODE_ALL = 2'd3;

	localparam logic [CW-1:0] NZ_RESET = CW'(1) << FB;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [2:0][CW-1:0] vert_t;        // [0] x, [1] y, [2] z

	typedef struct packed {
		logic [1:0] mode;
		vert_t t0;
		vert_t t1;
		vert_t t2;
		logic [1:0] dz;
	} side_t;
endpackage
`default_nettype wire

>>> sv/tpc_if.sv
// word channels of the triangle plane clipper
`default_nettype none
interface tpc_in_if import tpc_pkg::*; ();
	logic valid;
	logic ready;
	coord_t a_x, a_y, a_z;
	coord_t b_x, b_y, b_z;
	coord_t c_x, c_y, c_z;
	modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

interface tpc_out_if import tpc_pkg::*; ();
	logic valid;
	logic ready;
	coord_t out_a_x, out_a_y, out_a_z;
	coord_t out_b_x, out_b_y, out_b_z;
	coord_t out_c_x, out_c_y, out_c_z;
	logic last_of_run;
	modport source(output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
		out_c_x, out_c_y, out_c_z, last_of_run, input ready);
	modport sink(input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
		out_c_x, out_c_y, out_c_z, last_of_run, output ready);
endinterface
`default_nettype wire

>>> sv/tpc_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module tpc_div import tpc_pkg::*; (
	input wire logic clk,
	input wire logic en,
	input wire logic [MW-1:0] num,
	input wire logic [DVW-1:0] den,
	output logic [QW-1:0] quot
);
	logic [DVW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [QW-1:0] q_s [QW];
	logic [DVW-1:0] den_s [QW];

	logic [DVW-1:0] rem_in [QW];
	logic [DVW-1:0] den_in [QW];
	logic [QW-1:0] low_in [QW];
	logic [QW-1:0] q_in [QW];
	logic [DVW:0] trial [QW];
	logic ge [QW];

	always_comb begin
		// top part of the dividend is already below the divisor
		rem_in[0] = num[MW-1:QW];
		low_in[0] = num[QW-1:0];
		q_in[0] = '0;
		den_in[0] = den;
		for (int k = 1; k < QW; k++) begin
			rem_in[k] = rem_s[k-1];
			low_in[k] = low_s[k-1];
			q_in[k] = q_s[k-1];
			den_in[k] = den_s[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			trial[k] = {rem_in[k], low_in[k][QW-1]};
			ge[k] = trial[k] >= {1'b0, den_in[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k] <= ge[k] ? DVW'(trial[k] - {1'b0, den_in[k]}) : DVW'(trial[k]);
				low_s[k] <= {low_in[k][QW-2:0], 1'b0};
				q_s[k] <= {q_in[k][QW-2:0], ge[k]};
				den_s[k] <= den_in[k];
			end
		end
	end

	assign quot = q_s[QW-1];
endmodule
`default_nettype wire

>>> sv/triangle_plane_clipper.sv
// triangle plane clipper top level: plane registers, distance, weights, crossings
// pipeline: 41 register stages (input stage, six arithmetic stages, 33 divider stages,
// output register)
// throughput: one word per cycle when tri_out is ready; a two-triangle word waits for both
// reset: arst_n clears valid bits and sets the plane to normal (0, 0, 1.0), offset 0
`default_nettype none
module triangle_plane_clipper import tpc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [AW-1:0] paddr,
	input wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic pready,
	tpc_in_if.sink tri_in,
	tpc_out_if.source tri_out
);
	// plane registers
	coord_t nx_q, ny_q, nz_q, off_q;
	logic [RIW-1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[AW-1:ASH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= NZ_RESET;
			off_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_NX: nx_q <= coord_t'(pwdata[CW-1:0]);
				REG_NY: ny_q <= coord_t'(pwdata[CW-1:0]);
				REG_NZ: nz_q <= coord_t'(pwdata[CW-1:0]);
				REG_OFF: off_q <= coord_t'(pwdata[CW-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NX: prdata = APB_DW'(nx_q);
			REG_NY: prdata = APB_DW'(ny_q);
			REG_NZ: prdata = APB_DW'(nz_q);
			REG_OFF: prdata = APB_DW'(off_q);
			default: prdata = '0;
		endcase
	end

	// one advance for the whole pipe: it moves whenever the output register can take a word
	logic adv;
	logic ov_q, ph_q, two_q;
	logic out_done;

	assign out_done = ov_q && tri_out.ready && (!two_q || ph_q);
	assign adv = !ov_q || out_done;
	assign tri_in.ready = adv;

	// stage 1: input word
	logic v_s1;
	vert_t vin_s1 [3];

	// stage 2: normal times coordinate products
	logic v_s2;
	vert_t vt_s2 [3];
	logic signed [PW-1:0] prod_s2 [3][3];
	logic signed [DW-1:0] offt_s2;

	// stage 3: plane distances
	logic v_s3;
	vert_t vt_s3 [3];
	logic signed [DW-1:0] d_s3 [3];

	// stage 4: classification and edge selection
	logic v_s4;
	logic [1:0] mode_s4;
	vert_t t_s4 [3];
	vert_t co_s4 [2];
	logic [DW-1:0] wo_s4 [2];
	logic [DW-1:0] wi_s4 [2];

	// stage 5: normalized weights, coordinate differences
	logic v_s5;
	logic [1:0] mode_s5;
	vert_t t_s5 [3];
	logic [WB-1:0] wos_s5 [2];
	logic [WB:0] dsum_s5 [2];
	logic signed [FW-1:0] diff_s5 [6];

	// stage 6: split products difference times weight
	logic v_s6;
	logic [1:0] mode_s6;
	vert_t t_s6 [3];
	logic [WB:0] dsum_s6 [2];
	logic signed [MPW-1:0] plo_s6 [6];
	logic signed [MPW-1:0] phi_s6 [6];

	// stage 7: biased dividend and divisor
	logic v_s7;
	side_t side_s7;
	logic [MW-1:0] m_s7 [6];
	logic [DVW-1:0] den_s7 [2];

	// divider stages
	logic dval_s [QW];
	side_t dside_s [QW];
	logic [QW-1:0] quot [6];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k < QW; k++) dval_s[k] <= 1'b0;
		end else if (adv) begin
			v_s1 <= tri_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			dval_s[0] <= v_s7;
			for (int k = 1; k < QW; k++) dval_s[k] <= dval_s[k-1];
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (adv) begin
			vin_s1[0] <= {tri_in.a_z, tri_in.a_y, tri_in.a_x};
			vin_s1[1] <= {tri_in.b_z, tri_in.b_y, tri_in.b_x};
			vin_s1[2] <= {tri_in.c_z, tri_in.c_y, tri_in.c_x};
		end
	end

	// stage 2: nine products, offset scaled to the product format
	coord_t norm [3];
	assign norm[0] = nx_q;
	assign norm[1] = ny_q;
	assign norm[2] = nz_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				vt_s2[i] <= vin_s1[i];
				for (int c = 0; c < 3; c++)
					prod_s2[i][c] <= PW'(norm[c] * $signed(vin_s1[i][c]));
			end
			offt_s2 <= DW'(off_q) <<< FB;
		end
	end

	// stage 3: distance sums, exact
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				vt_s3[i] <= vt_s2[i];
				d_s3[i] <= DW'(prod_s2[i][0]) + DW'(prod_s2[i][1]) + DW'(prod_s2[i][2])
					+ offt_s2;
			end
		end
	end

	// stage 4: inside test, pick both edges that cross the plane
	function automatic vert_t pick_v(input vert_t v0, input vert_t v1, input vert_t v2,
		input logic [1:0] i);
		case (i)
			2'd0: pick_v = v0;
			2'd1: pick_v = v1;
			default: pick_v = v2;
		endcase
	endfunction

	function automatic logic [DW-1:0] pick_d(input logic [DW-1:0] d0,
		input logic [DW-1:0] d1, input logic [DW-1:0] d2, input logic [1:0] i);
		case (i)
			2'd0: pick_d = d0;
			2'd1: pick_d = d1;
			default: pick_d = d2;
		endcase
	endfunction

	logic [2:0] ins;
	logic [1:0] mode_c;
	logic [1:0] ia, io1, io2, io, ip, iq;
	logic [1:0] in_idx [2];
	logic [1:0] out_idx [2];

	always_comb begin
		for (int i = 0; i < 3; i++) ins[i] = !d_s3[i][DW-1] && (d_s3[i] != '0);
		if (ins == 3'b000) mode_c = MODE_NONE;
		else if (ins == 3'b111) mode_c = MODE_ALL;
		else if (ins inside {3'b001, 3'b010, 3'b100}) mode_c = MODE_ONE;
		else mode_c = MODE_TWO;
		// one inside: the inside vertex and the outside ones in input order
		ia = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
		io1 = (ia == 2'd0) ? 2'd1 : 2'd0;
		io2 = (ia == 2'd2) ? 2'd1 : 2'd2;
		// two inside: the outside vertex and the inside ones in input order
		io = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
		ip = (io == 2'd0) ? 2'd1 : 2'd0;
		iq = (io == 2'd2) ? 2'd1 : 2'd2;
		if (mode_c == MODE_ONE) begin
			in_idx[0] = ia;
			out_idx[0] = io1;
			in_idx[1] = ia;
			out_idx[1] = io2;
		end else begin
			in_idx[0] = ip;
			out_idx[0] = io;
			in_idx[1] = iq;
			out_idx[1] = io;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s4 <= mode_c;
			if (mode_c == MODE_ALL) begin
				t_s4[0] <= vt_s3[0];
				t_s4[1] <= vt_s3[1];
			end else begin
				t_s4[0] <= pick_v(vt_s3[0], vt_s3[1], vt_s3[2], in_idx[0]);
				t_s4[1] <= pick_v(vt_s3[0], vt_s3[1], vt_s3[2], in_idx[1]);
			end
			t_s4[2] <= vt_s3[2];
			for (int l = 0; l < 2; l++) begin
				co_s4[l] <= pick_v(vt_s3[0], vt_s3[1], vt_s3[2], out_idx[l]);
				wo_s4[l] <= pick_d(d_s3[0], d_s3[1], d_s3[2], in_idx[l]);
				wi_s4[l] <= DW'(-pick_d(d_s3[0], d_s3[1], d_s3[2], out_idx[l]));
			end
		end
	end

	// stage 5: shift both weights until the larger fits the weight width
	logic [SHW-1:0] sh [2];
	logic [WB-1:0] wos_c [2];
	logic [WB-1:0] wis_c [2];
	logic [DW-1:0] orw [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			orw[l] = wo_s4[l] | wi_s4[l];
			sh[l] = '0;
			for (int j = WB; j < DW; j++)
				if (orw[l][j]) sh[l] = SHW'(j - WB + 1);
			wos_c[l] = WB'(wo_s4[l] >> sh[l]);
			wis_c[l] = WB'(wi_s4[l] >> sh[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s5 <= mode_s4;
			for (int i = 0; i < 3; i++) t_s5[i] <= t_s4[i];
			for (int l = 0; l < 2; l++) begin
				wos_s5[l] <= wos_c[l];
				dsum_s5[l] <= (WB+1)'(wos_c[l]) + (WB+1)'(wis_c[l]);
				for (int c = 0; c < 3; c++)
					diff_s5[l*3+c] <= FW'($signed(co_s4[l][c])) - FW'($signed(t_s4[l][c]));
			end
		end
	end

	// stage 6: difference times outer weight, split in two halves
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s6 <= mode_s5;
			for (int i = 0; i < 3; i++) t_s6[i] <= t_s5[i];
			for (int l = 0; l < 2; l++) begin
				dsum_s6[l] <= dsum_s5[l];
				for (int c = 0; c < 3; c++) begin
					plo_s6[l*3+c] <= MPW'(diff_s5[l*3+c]
						* $signed({1'b0, wos_s5[l][WH-1:0]}));
					phi_s6[l*3+c] <= MPW'(diff_s5[l*3+c]
						* $signed({1'b0, wos_s5[l][WB-1:WH]}));
				end
			end
		end
	end

	// stage 7: dividend 2*diff*w + D, biased by 2^QW * D so the quotient is never negative
	logic signed [MW:0] dext [2];
	logic signed [MW:0] msum [6];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			dext[l] = {{(MW-WB){1'b0}}, dsum_s6[l]};
			for (int c = 0; c < 3; c++)
				msum[l*3+c] = (((MW+1)'(phi_s6[l*3+c]) <<< WH) + (MW+1)'(plo_s6[l*3+c]))
					* 2 + dext[l] + (dext[l] <<< QW);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7.mode <= mode_s6;
			side_s7.t0 <= t_s6[0];
			side_s7.t1 <= t_s6[1];
			side_s7.t2 <= t_s6[2];
			for (int l = 0; l < 2; l++) begin
				side_s7.dz[l] <= (dsum_s6[l] == '0);
				den_s7[l] <= {dsum_s6[l], 1'b0};
			end
			for (int k = 0; k < 6; k++) m_s7[k] <= msum[k][MW-1:0];
		end
	end

	// six crossing coordinates, each through its own divider pipe
	for (genvar k = 0; k < 6; k++) begin : g_div
		tpc_div u_div (
			.clk(clk),
			.en(adv),
			.num(m_s7[k]),
			.den(den_s7[k/3]),
			.quot(quot[k])
		);
	end

	// side data rides along with the divider stages
	always_ff @(posedge clk) begin
		if (adv) begin
			dside_s[0] <= side_s7;
			for (int k = 1; k < QW; k++) dside_s[k] <= dside_s[k-1];
		end
	end

	// crossing = inside vertex + unbiased quotient; a zero weight sum keeps the inside vertex
	side_t sd;
	vert_t xv [2];

	assign sd = dside_s[QW-1];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			for (int c = 0; c < 3; c++) begin
				if (sd.dz[l]) xv[l][c] = (l == 0) ? sd.t0[c] : sd.t1[c];
				else xv[l][c] = ((l == 0) ? sd.t0[c] : sd.t1[c]) + quot[l*3+c][CW-1:0];
			end
		end
	end

	// output register: both triangles of a word, sent one after the other
	vert_t o0_q [3];
	vert_t o1_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			ph_q <= 1'b0;
		end else if (adv) begin
			// a word with no vertex inside is dropped here
			ov_q <= dval_s[QW-1] && (sd.mode != MODE_NONE);
			ph_q <= 1'b0;
		end else if (ov_q && tri_out.ready && two_q && !ph_q) begin
			ph_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			two_q <= (sd.mode == MODE_TWO);
			o0_q[0] <= sd.t0;
			case (sd.mode)
				MODE_ONE: begin
					o0_q[1] <= xv[0];
					o0_q[2] <= xv[1];
				end
				MODE_TWO: begin
					o0_q[1] <= sd.t1;
					o0_q[2] <= xv[0];
				end
				default: begin
					o0_q[1] <= sd.t1;
					o0_q[2] <= sd.t2;
				end
			endcase
			o1_q[0] <= xv[0];
			o1_q[1] <= sd.t1;
			o1_q[2] <= xv[1];
		end
	end

	vert_t cur [3];

	always_comb begin
		for (int i = 0; i < 3; i++) cur[i] = ph_q ? o1_q[i] : o0_q[i];
	end

	assign tri_out.valid = ov_q;
	assign tri_out.out_a_x = cur[0][0];
	assign tri_out.out_a_y = cur[0][1];
	assign tri_out.out_a_z = cur[0][2];
	assign tri_out.out_b_x = cur[1][0];
	assign tri_out.out_b_y = cur[1][1];
	assign tri_out.out_b_z = cur[1][2];
	assign tri_out.out_c_x = cur[2][0];
	assign tri_out.out_c_y = cur[2][1];
	assign tri_out.out_c_z = cur[2][2];
	assign tri_out.last_of_run = ph_q || !two_q;
endmodule
`default_nettype wire
